### hw/rtl/four_function_calculator_keys_defines.svh
// assertion macros for the calculator key engine
`ifndef FOUR_FUNCTION_CALCULATOR_KEYS_DEFINES_SVH
`define FOUR_FUNCTION_CALCULATOR_KEYS_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define FFC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define FFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ffc_pkg.sv
// shared types, constants and key codes of the calculator key engine
package ffc_pkg;

   localparam int DISPLAY_DIGITS_DEF = 8;
   localparam int OUT_DIGITS = 8;
   localparam int KEY_W = 5;
   localparam int DIG_W = 4;
   localparam int TONE_W = 11;
   localparam int SYM_W = 3;
   localparam int VAL_W = 32;
   // wide enough for a held value times ten and a 32 by 32 product
   localparam int WIDE_W = 64;

   localparam logic [KEY_W-1:0] KEY_NONE = 5'd0;
   localparam logic [KEY_W-1:0] KEY_ZERO = 5'd10;
   localparam logic [KEY_W-1:0] KEY_ADD = 5'd11;
   localparam logic [KEY_W-1:0] KEY_SUB = 5'd12;
   localparam logic [KEY_W-1:0] KEY_MUL = 5'd13;
   localparam logic [KEY_W-1:0] KEY_DIV = 5'd14;
   localparam logic [KEY_W-1:0] KEY_EQUALS = 5'd15;
   localparam logic [KEY_W-1:0] KEY_CLEAR = 5'd16;

   localparam logic [DIG_W-1:0] DIG_BLANK = 4'd10;
   localparam logic [DIG_W-1:0] DIG_MINUS = 4'd11;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // datapath command codes
   localparam logic [2:0] CMD_NONE = 3'd0;
   localparam logic [2:0] CMD_DIGIT = 3'd1;
   localparam logic [2:0] CMD_OPER = 3'd2;
   localparam logic [2:0] CMD_EQUALS = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;
   localparam logic [2:0] CMD_START = 3'd5;

   typedef struct packed {
      logic          start;
      logic [2:0]    cmd;
      logic [KEY_W-1:0] key;
   } ffc_cmd_type;

   typedef struct packed {
      logic done;
   } ffc_status_type;

   function automatic logic [TONE_W-1:0] tone_of(input logic [KEY_W-1:0] key);
      logic [TONE_W-1:0] t;
      case (key)
         5'd1: t = 11'd250;
         5'd2: t = 11'd300;
         5'd3: t = 11'd330;
         5'd4: t = 11'd360;
         5'd5: t = 11'd390;
         5'd6: t = 11'd420;
         5'd7: t = 11'd450;
         5'd8: t = 11'd520;
         5'd9: t = 11'd555;
         5'd10: t = 11'd666;
         5'd11: t = 11'd700;
         5'd12: t = 11'd780;
         5'd13: t = 11'd880;
         5'd14: t = 11'd1000;
         5'd15: t = 11'd1100;
         5'd16: t = 11'd1200;
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [DIG_W-1:0] greeting_of(input int k);
      logic [DIG_W-1:0] g;
      case (k)
         0: g = 4'd0;
         1: g = 4'd4;
         2: g = 4'd4;
         3: g = 4'd1;
         4: g = 4'd6;
         5: g = 4'd5;
         6: g = 4'd5;
         7: g = 4'd0;
         default: g = DIG_BLANK;
      endcase
      return g;
   endfunction

   function automatic longint pow10(input int e);
      longint r;
      r = 1;
      for (int i = 0; i < e; i++) r = r * 10;
      return r;
   endfunction

   function automatic longint clip_hi(input longint v);
      return (v > 64'sd2147483647) ? 64'sd2147483647 : v;
   endfunction

   function automatic longint clip_lo(input longint v);
      return (v < -64'sd2147483648) ? -64'sd2147483648 : v;
   endfunction

endpackage

### hw/rtl/ffc_ctrl.sv
// controller state machine of the calculator key engine
module ffc_ctrl
   import ffc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [KEY_W-1:0]     key_code,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output ffc_cmd_type          cmd,
   input  ffc_status_type       status,
   output logic [TONE_W-1:0]    tone_hz,
   output logic [SYM_W-1:0]     operator_symbol
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WORK = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0] state_ff, state_in;
   logic started_ff, started_in;
   logic [TONE_W-1:0] tone_ff, tone_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic [2:0] kind;
   logic accept;
   logic act;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign tone_hz = tone_ff;
   assign operator_symbol = sym_ff;
   assign act = started_ff || (key_code == KEY_CLEAR);

   always_comb begin
      if (!act || key_code == KEY_NONE || key_code > KEY_CLEAR) begin
         kind = CMD_NONE;
      end else if (key_code <= KEY_ZERO) begin
         kind = CMD_DIGIT;
      end else if (key_code <= KEY_DIV) begin
         kind = CMD_OPER;
      end else if (key_code == KEY_EQUALS) begin
         kind = CMD_EQUALS;
      end else if (!started_ff) begin
         kind = CMD_START;
      end else begin
         kind = CMD_CLEAR;
      end
   end

   always_comb begin
      cmd.start = accept;
      cmd.cmd = kind;
      cmd.key = key_code;
   end

   always_comb begin
      state_in = state_ff;
      started_in = started_ff;
      tone_in = tone_ff;
      sym_in = sym_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WORK;
               started_in = act;
               tone_in = act ? tone_of(key_code) : '0;
               sym_in = (key_code >= KEY_ADD && key_code <= KEY_CLEAR)
                  ? SYM_W'(key_code - KEY_ZERO) : '0;
            end
         end
         ST_WORK: begin
            if (status.done) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         started_ff <= started_in;
      end
      tone_ff <= tone_in;
      sym_ff <= sym_in;
   end

endmodule

### hw/rtl/ffc_datapath.sv
// operand registers, arithmetic, divider and digit conversion of the calculator
module ffc_datapath
   import ffc_pkg::*;
#(
   parameter int DISPLAY_DIGITS = DISPLAY_DIGITS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  ffc_cmd_type          cmd,
   output ffc_status_type       status,
   output logic [DIG_W*OUT_DIGITS-1:0] digits,
   output logic                 decimal_point,
   output logic                 overflow
);
   `include "four_function_calculator_keys_defines.svh"

   localparam longint IntHi = clip_hi(pow10(DISPLAY_DIGITS + 1) - 1);
   localparam longint IntLo = clip_lo(-(pow10(DISPLAY_DIGITS) - 1));
   localparam longint QuoHi = clip_hi(pow10(DISPLAY_DIGITS) - 1);
   localparam longint QuoLo = clip_lo(-(pow10(DISPLAY_DIGITS - 1) - 1));
   // products beyond these give a result outside the integer range
   localparam longint MulHi = IntHi * 10 + 9;
   localparam longint MulLo = IntLo * 10 - 9;
   localparam int DW = $clog2(DISPLAY_DIGITS + 1);
   localparam int AW = $clog2(DISPLAY_DIGITS);
   localparam int DIVW = WIDE_W;
   localparam int DCW = $clog2(DIVW + 1);
   // x / 10 = (x * RECIP10) >> 35, exact for x below 2^34
   localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
   // a product magnitude is split into an upper byte and 27 low bits
   localparam int MUL_SPLIT = 27;

   // sequencer steps
   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_MUL = 4'd1;
   localparam logic [3:0] PH_SAT = 4'd2;
   localparam logic [3:0] PH_DIV = 4'd3;
   localparam logic [3:0] PH_DIVEND = 4'd4;
   localparam logic [3:0] PH_TEN = 4'd5;
   localparam logic [3:0] PH_CONV = 4'd6;
   localparam logic [3:0] PH_DONE = 4'd7;
   localparam logic [3:0] PH_MULHI = 4'd8;
   localparam logic [3:0] PH_MULLO = 4'd9;

   logic [3:0] ph_ff, ph_in;
   logic pend_ff, pend_in;
   logic [1:0] op_ff, op_in;
   logic signed [VAL_W-1:0] entry_ff, entry_in;
   logic signed [VAL_W-1:0] held_ff, held_in;
   logic [DIG_W-1:0] shown_ff [DISPLAY_DIGITS];
   logic [DIG_W-1:0] shown_in [DISPLAY_DIGITS];
   logic point_ff, point_in;
   logic ovf_ff, ovf_in;
   // scratch value and destination flags
   logic signed [WIDE_W-1:0] acc_ff, acc_in;
   logic quot_ff, quot_in;
   logic to_entry_ff, to_entry_in;
   logic to_held_ff, to_held_in;
   // divider
   logic [DIVW-1:0] num_ff, num_in;
   logic [DIVW-1:0] rem_ff, rem_in;
   logic [DIVW-1:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   // conversion
   logic [WIDE_W-1:0] mag_ff, mag_in;
   logic cneg_ff, cneg_in;
   logic [DW-1:0] pos_ff, pos_in;
   logic [1:0] mind_ff, mind_in;

   logic signed [WIDE_W-1:0] sat_v;
   logic sat_o;
   logic [DIVW:0] trial;
   logic [31:0] d10_in;
   logic [63:0] d10_p;
   logic [31:0] d10_q;
   logic [3:0] d10_r;
   logic signed [WIDE_W-1:0] mul_q;

   always_comb begin
      sat_o = 1'b0;
      sat_v = acc_ff;
      if (quot_ff) begin
         if (acc_ff > QuoHi) begin sat_v = QuoHi; sat_o = 1'b1; end
         else if (acc_ff < QuoLo) begin sat_v = QuoLo; sat_o = 1'b1; end
      end else begin
         if (acc_ff > IntHi) begin sat_v = IntHi; sat_o = 1'b1; end
         else if (acc_ff < IntLo) begin sat_v = IntLo; sat_o = 1'b1; end
      end
   end

   assign trial = {rem_ff, num_ff[DIVW-1]} - {1'b0, den_ff};

   // shared divide by ten
   always_comb begin
      if (ph_ff == PH_MULHI) d10_in = 32'(mag_ff[MUL_SPLIT+7:MUL_SPLIT]);
      else d10_in = mag_ff[31:0];
      d10_p = 64'(d10_in) * 64'(RECIP10);
      d10_q = 32'(d10_p[63:35]);
      d10_r = 4'(d10_in - d10_q * 32'd10);
   end

   assign mul_q = (acc_ff <<< MUL_SPLIT) + WIDE_W'(d10_q);

   always_comb begin
      ph_in = ph_ff;
      pend_in = pend_ff;
      op_in = op_ff;
      entry_in = entry_ff;
      held_in = held_ff;
      shown_in = shown_ff;
      point_in = point_ff;
      ovf_in = ovf_ff;
      acc_in = acc_ff;
      quot_in = quot_ff;
      to_entry_in = to_entry_ff;
      to_held_in = to_held_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      dcnt_in = dcnt_ff;
      mag_in = mag_ff;
      cneg_in = cneg_ff;
      pos_in = pos_ff;
      mind_in = mind_ff;
      case (ph_ff)
         PH_IDLE: begin
            if (cmd.start) begin
               ovf_in = 1'b0;
               quot_in = 1'b0;
               to_entry_in = 1'b0;
               to_held_in = 1'b0;
               ph_in = PH_DONE;
               case (cmd.cmd)
                  CMD_DIGIT: begin
                     acc_in = WIDE_W'(entry_ff) * 10
                        + ((cmd.key == KEY_ZERO) ? '0 : WIDE_W'(cmd.key) * 10);
                     to_entry_in = 1'b1;
                     ph_in = PH_SAT;
                  end
                  CMD_OPER: begin
                     if (!pend_ff) begin
                        held_in = entry_ff;
                        entry_in = '0;
                        pend_in = 1'b1;
                     end
                     op_in = 2'(cmd.key - KEY_ADD);
                  end
                  CMD_EQUALS: begin
                     if (pend_ff) begin
                        pend_in = 1'b0;
                        entry_in = '0;
                        to_held_in = 1'b1;
                        case (op_ff)
                           OP_ADD: begin
                              acc_in = WIDE_W'(held_ff) + WIDE_W'(entry_ff);
                              ph_in = PH_SAT;
                           end
                           OP_SUB: begin
                              acc_in = WIDE_W'(held_ff) - WIDE_W'(entry_ff);
                              ph_in = PH_SAT;
                           end
                           OP_MUL: begin
                              acc_in = WIDE_W'(held_ff) * WIDE_W'(entry_ff);
                              ph_in = PH_MUL;
                           end
                           default: begin
                              quot_in = 1'b1;
                              point_in = 1'b1;
                              if (entry_ff == 0) begin
                                 ovf_in = 1'b1;
                                 acc_in = (held_ff > 0) ? QuoHi
                                    : (held_ff < 0) ? QuoLo : '0;
                                 ph_in = PH_SAT;
                              end else begin
                                 neg_in = held_ff[VAL_W-1] ^ entry_ff[VAL_W-1];
                                 num_in = held_ff[VAL_W-1]
                                    ? DIVW'(-(WIDE_W'(held_ff) * 10))
                                    : DIVW'(WIDE_W'(held_ff) * 10);
                                 den_in = entry_ff[VAL_W-1]
                                    ? DIVW'(-WIDE_W'(entry_ff)) : DIVW'(entry_ff);
                                 rem_in = '0;
                                 dcnt_in = DCW'(DIVW);
                                 ph_in = PH_DIV;
                              end
                           end
                        endcase
                     end else begin
                        entry_in = held_ff;
                        acc_in = WIDE_W'(held_ff);
                        ph_in = PH_SAT;
                     end
                  end
                  CMD_CLEAR, CMD_START: begin
                     for (int p = 0; p < DISPLAY_DIGITS; p++) shown_in[p] = DIG_BLANK;
                     point_in = 1'b0;
                     entry_in = '0;
                     pend_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         PH_MUL: begin
            // truncate toward zero by ten
            if (acc_ff > MulHi) begin
               acc_in = IntHi + 1;
               ph_in = PH_SAT;
            end else if (acc_ff < MulLo) begin
               acc_in = IntLo - 1;
               ph_in = PH_SAT;
            end else begin
               neg_in = acc_ff < 0;
               mag_in = (acc_ff < 0) ? WIDE_W'(-acc_ff) : WIDE_W'(acc_ff);
               ph_in = PH_MULHI;
            end
         end
         PH_MULHI: begin
            // upper byte first, its remainder joins the low bits
            acc_in = WIDE_W'(d10_q);
            mag_in = WIDE_W'({d10_r, mag_ff[MUL_SPLIT-1:0]});
            ph_in = PH_MULLO;
         end
         PH_MULLO: begin
            acc_in = neg_ff ? -mul_q : mul_q;
            ph_in = PH_SAT;
         end
         PH_DIV: begin
            if (!trial[DIVW]) rem_in = trial[DIVW-1:0];
            else rem_in = {rem_ff[DIVW-2:0], num_ff[DIVW-1]};
            num_in = {num_ff[DIVW-2:0], ~trial[DIVW]};
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == 1) ph_in = PH_DIVEND;
         end
         PH_DIVEND: begin
            acc_in = neg_ff ? -$signed(num_ff) : $signed(num_ff);
            ph_in = PH_SAT;
         end
         PH_SAT: begin
            ovf_in = ovf_ff | sat_o;
            acc_in = sat_v;
            if (to_entry_ff) entry_in = VAL_W'(sat_v);
            if (to_held_ff) held_in = VAL_W'(sat_v);
            if (!to_held_ff && !to_entry_ff) entry_in = VAL_W'(sat_v);
            ph_in = quot_ff ? PH_CONV : PH_TEN;
            cneg_in = sat_v < 0;
            mag_in = (sat_v < 0) ? WIDE_W'(-sat_v) : WIDE_W'(sat_v);
            mind_in = quot_ff ? 2'd2 : 2'd1;
            pos_in = DW'(DISPLAY_DIGITS);
            for (int p = 0; p < DISPLAY_DIGITS; p++) shown_in[p] = DIG_BLANK;
         end
         PH_TEN: begin
            // a value that truncates to zero shows no minus
            mag_in = WIDE_W'(d10_q);
            cneg_in = cneg_ff && (d10_q != 0);
            ph_in = PH_CONV;
         end
         PH_CONV: begin
            if (pos_ff != 0 && (mind_ff != 0 || mag_ff != 0)) begin
               shown_in[AW'(pos_ff - 1'b1)] = d10_r;
               mag_in = WIDE_W'(d10_q);
               pos_in = pos_ff - 1'b1;
               if (mind_ff != 0) mind_in = mind_ff - 1'b1;
            end else begin
               if (cneg_ff && pos_ff != 0) shown_in[AW'(pos_ff - 1'b1)] = DIG_MINUS;
               ph_in = PH_DONE;
            end
         end
         PH_DONE: ph_in = PH_IDLE;
         default: ph_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
         pend_ff <= 1'b0;
         op_ff <= OP_ADD;
         entry_ff <= '0;
         held_ff <= '0;
         point_ff <= 1'b0;
         ovf_ff <= 1'b0;
         for (int p = 0; p < DISPLAY_DIGITS; p++)
            shown_ff[p] <= greeting_of(p + 8 - DISPLAY_DIGITS);
      end else begin
         ph_ff <= ph_in;
         pend_ff <= pend_in;
         op_ff <= op_in;
         entry_ff <= entry_in;
         held_ff <= held_in;
         point_ff <= point_in;
         ovf_ff <= ovf_in;
         shown_ff <= shown_in;
      end
      acc_ff <= acc_in;
      quot_ff <= quot_in;
      to_entry_ff <= to_entry_in;
      to_held_ff <= to_held_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      dcnt_ff <= dcnt_in;
      mag_ff <= mag_in;
      cneg_ff <= cneg_in;
      pos_ff <= pos_in;
      mind_ff <= mind_in;
   end

   assign status.done = (ph_ff == PH_DONE);
   assign decimal_point = point_ff;
   assign overflow = ovf_ff;

   always_comb begin
      for (int j = 0; j < OUT_DIGITS; j++) begin
         if (j + DISPLAY_DIGITS - OUT_DIGITS >= 0)
            digits[j*DIG_W +: DIG_W] = shown_ff[j + DISPLAY_DIGITS - OUT_DIGITS];
         else
            digits[j*DIG_W +: DIG_W] = DIG_BLANK;
      end
   end

   `FFC_ASSERT_NEXT(a_div_runs, clock, reset, ph_ff == PH_DIV && dcnt_ff == 1,
      ph_ff == PH_DIVEND, "divider did not finish")
   `FFC_ASSERT_IMP(a_no_start_busy, clock, reset, ph_ff != PH_IDLE, !cmd.start,
      "command while busy")
   `FFC_ASSERT_NEXT(a_sat_ovf, clock, reset, ph_ff == PH_SAT && sat_o, ovf_ff,
      "saturation without overflow")

endmodule

### hw/rtl/four_function_calculator_keys.sv
// Calculator key engine: one key item in, one display item out, one item worked
// at a time. An operator, clear or ignored key goes straight to the done step; a
// digit or an add or subtract equals is saturated and divided by ten first; a
// multiply first scales its product in three steps (one if it is out of range);
// a divide runs the 64 steps of the one-bit-a-step restoring divider unless it
// divides by zero; the rest is digit conversion at one digit a cycle. The item
// stays on rsp until taken, and the next key is accepted from the cycle after.
module four_function_calculator_keys
   import ffc_pkg::*;
#(
   parameter int DISPLAY_DIGITS = DISPLAY_DIGITS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // key_code[4:0], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // digit_0..digit_7 [31:0], decimal_point [32], tone_hz [43:33],
   // operator_symbol [46:44], overflow [47]
   output logic [47:0] rsp_tdata
);
   `include "four_function_calculator_keys_defines.svh"

   ffc_cmd_type cmd;
   ffc_status_type status;
   logic [DIG_W*OUT_DIGITS-1:0] digits;
   logic point;
   logic ovf;
   logic [TONE_W-1:0] tone;
   logic [SYM_W-1:0] sym;

   ffc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .key_code(req_tdata[KEY_W-1:0]),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .status(status),
      .tone_hz(tone), .operator_symbol(sym)
   );

   ffc_datapath #(.DISPLAY_DIGITS(DISPLAY_DIGITS)) u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .status(status),
      .digits(digits), .decimal_point(point), .overflow(ovf)
   );

   assign rsp_tdata = {ovf, sym, tone, point, digits};

   `FFC_ASSERT_IMP(a_excl, clock, reset, rsp_tvalid, !req_tready,
      "input taken while item waits")
   `FFC_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "waiting item changed")

endmodule

### tb/sv/tb.sv
// self-checking testbench for the calculator key engine
module tb;
   import ffc_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam longint INT_HI = 999999999;
   localparam longint INT_LO = -99999999;
   localparam longint QUO_HI = 99999999;
   localparam longint QUO_LO = -9999999;

   typedef struct packed {
      logic        ovf;
      logic [2:0]  sym;
      logic [10:0] tone;
      logic        point;
      logic [31:0] digits;
   } display_item_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // key_code[4:0], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready;
   // digit_0..digit_7 [31:0], decimal_point [32], tone_hz [43:33],
   // operator_symbol [46:44], overflow [47]
   logic [47:0] rsp_tdata;

   four_function_calculator_keys u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // calculator state mirror
   bit          calc_started;
   bit          op_pending;
   logic [1:0]  pending_op;
   longint      entry_val;
   longint      held_val;
   logic [3:0]  shown [8];
   bit          point_on;

   display_item_t expected_displays[$];
   int          mismatches;
   int          key_count;
   int          display_count;
   int          idle_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                    inout bit ovf);
      if (v > hi) begin
         ovf = 1'b1;
         return hi;
      end
      if (v < lo) begin
         ovf = 1'b1;
         return lo;
      end
      return v;
   endfunction

   task automatic show_value(input longint n, input int min_digits);
      bit     neg;
      longint mag;
      int     p;
      int     cnt;
      neg = n < 0;
      mag = neg ? -n : n;
      p = 7;
      cnt = 0;
      for (int i = 0; i < 8; i++) shown[i] = DIG_BLANK;
      while (p >= 0 && (cnt < min_digits || mag != 0)) begin
         shown[p] = 4'(mag % 10);
         mag = mag / 10;
         p--;
         cnt++;
      end
      if (neg && p >= 0) shown[p] = DIG_MINUS;
   endtask

   task automatic predict_key(input logic [4:0] key);
      display_item_t d;
      bit     ovf;
      longint a;
      longint b;
      longint r;
      ovf = 1'b0;
      d = '0;
      d.sym = (key >= KEY_ADD && key <= KEY_CLEAR) ? 3'(key - KEY_ZERO) : 3'd0;
      if (key == KEY_CLEAR && !calc_started) begin
         for (int i = 0; i < 8; i++) shown[i] = DIG_BLANK;
         point_on = 1'b0;
         calc_started = 1'b1;
      end
      if (calc_started && key >= 5'd1 && key <= KEY_CLEAR) begin
         d.tone = tone_of(key);
         if (key <= KEY_ZERO) begin
            entry_val = clamp(entry_val * 10 + ((key == KEY_ZERO) ? 0 : key) * 10,
                              INT_LO, INT_HI, ovf);
            show_value(entry_val / 10, 1);
         end else if (key <= KEY_DIV) begin
            if (!op_pending) begin
               held_val = entry_val;
               entry_val = 0;
               op_pending = 1'b1;
            end
            pending_op = 2'(key - KEY_ADD);
         end else if (key == KEY_EQUALS) begin
            if (op_pending) begin
               a = held_val;
               b = entry_val;
               op_pending = 1'b0;
               if (pending_op == OP_DIV) begin
                  if (b == 0) begin
                     r = (a > 0) ? QUO_HI : (a < 0) ? QUO_LO : 0;
                     ovf = 1'b1;
                  end else begin
                     r = clamp((a * 10) / b, QUO_LO, QUO_HI, ovf);
                  end
                  show_value(r, 2);
                  point_on = 1'b1;
               end else begin
                  case (pending_op)
                     OP_ADD: r = a + b;
                     OP_SUB: r = a - b;
                     default: r = (a * b) / 10;
                  endcase
                  r = clamp(r, INT_LO, INT_HI, ovf);
                  show_value(r / 10, 1);
               end
               held_val = r;
               entry_val = 0;
            end else begin
               entry_val = held_val;
               show_value(entry_val / 10, 1);
            end
         end else begin
            for (int i = 0; i < 8; i++) shown[i] = DIG_BLANK;
            point_on = 1'b0;
            entry_val = 0;
            op_pending = 1'b0;
         end
      end
      for (int j = 0; j < 8; j++) d.digits[4*j +: 4] = shown[j];
      d.point = point_on;
      d.ovf = ovf;
      expected_displays.push_back(d);
   endtask

   task automatic send_key(input logic [4:0] key);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {3'b000, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_key(key);
      key_count++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained;
      while (expected_displays.size() != 0) @(negedge clock);
   endtask

   task automatic send_number(input int digits);
      for (int i = 0; i < digits; i++) send_key(KEY_W'($urandom_range(1, 10)));
   endtask

   // power-up keys are ignored, then clear starts the engine
   task automatic test_startup;
      send_key(KEY_NONE);
      send_key(5'd5);
      send_key(KEY_ADD);
      send_key(KEY_EQUALS);
      send_key(5'd31);
      send_key(KEY_CLEAR);
   endtask

   task automatic test_directed;
      send_number(10);                       // entry saturates
      send_key(KEY_CLEAR);
      send_key(5'd9); send_key(KEY_MUL);
      send_key(5'd9); send_key(KEY_EQUALS);  // product
      send_key(5'd7); send_key(KEY_DIV);
      send_key(5'd3); send_key(KEY_EQUALS);  // quotient lights point
      send_key(KEY_DIV); send_key(KEY_EQUALS); // divide by zero
      send_key(KEY_EQUALS);                  // redisplay held
      send_key(KEY_CLEAR);
      send_key(5'd2); send_key(KEY_SUB);
      send_key(5'd8); send_key(KEY_EQUALS);  // negative result
      send_key(KEY_DIV); send_key(KEY_ZERO); send_key(KEY_EQUALS);
      send_key(5'd17); send_key(KEY_CLEAR);
   endtask

   task automatic test_random(input int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 45) send_key(KEY_W'($urandom_range(1, 10)));
         else if (sel < 65) send_key(KEY_W'($urandom_range(KEY_ADD, KEY_DIV)));
         else if (sel < 82) send_key(KEY_EQUALS);
         else if (sel < 90) send_key(KEY_CLEAR);
         else if (sel < 95) send_key(KEY_NONE);
         else send_key(KEY_W'($urandom_range(0, 31)));
      end
   endtask

   task automatic test_backpressure;
      send_number(3);
      send_key(KEY_DIV);
      send_number(2);
      send_key(KEY_EQUALS);
      wait_drained;
      send_key(KEY_EQUALS);
   endtask

   always @(posedge clock) begin
      display_item_t got;
      display_item_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         display_count++;
         if (expected_displays.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", rsp_tdata);
         end else begin
            want = expected_displays.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: digits %h/%h point %b/%b tone %0d/%0d sym %0d/%0d ovf %b/%b",
                     want.digits, got.digits, want.point, got.point, want.tone, got.tone,
                     want.sym, got.sym, want.ovf, got.ovf);
            end
         end
      end
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[four_function_calculator_keys] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      send_idle_pct = 37;
      recv_idle_pct = 82;
      calc_started = 1'b0;
      op_pending = 1'b0;
      pending_op = OP_ADD;
      entry_val = 0;
      held_val = 0;
      point_on = 1'b0;
      for (int i = 0; i < 8; i++) shown[i] = greeting_of(i);
      mismatches = 0;
      key_count = 0;
      display_count = 0;
      idle_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_startup;
      test_directed;
      test_random(450);
      send_idle_pct = 82;
      recv_idle_pct = 37;
      test_backpressure;
      test_random(450);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(430);
      wait_drained;
      repeat (200) @(negedge clock);
      $display("covered %0d keys and %0d displays: digits, all operators, equals, clear,",
               key_count, display_count);
      $display("saturation, division by zero, ignored keys, and three idle profiles");
      if (mismatches == 0 && expected_displays.size() == 0)
         $display("[four_function_calculator_keys] OK");
      else
         $display("[four_function_calculator_keys] ERROR");
      $finish;
   end
endmodule
